// ===== hdl/laas_pkg.sv =====
// Shared types and constants for the learning automaton action selector.
// Used by learning_automaton_action_selector; depends on nothing else.
package laas_pkg;

    localparam int MAX_ACTIONS = 16;
    localparam int MAX_HISTORY = 4;

    localparam logic [2:0] MODE_SELECT  = 3'd0;
    localparam logic [2:0] MODE_UPDATE  = 3'd1;
    localparam logic [2:0] MODE_RESTORE = 3'd2;
    localparam logic [2:0] MODE_LOAD_IC = 3'd3;
    localparam logic [2:0] MODE_LOAD_C  = 3'd4;

    localparam logic [1:0] CFG_REWARD  = 2'd0;
    localparam logic [1:0] CFG_PENALTY = 2'd1;
    localparam logic [1:0] CFG_ACTIONS = 2'd2;
    localparam logic [1:0] CFG_HISTORY = 2'd3;

    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [24:0] ONE_Q24 = 25'h100_0000;

    typedef logic [32:0] t_prob;

endpackage

// ===== hdl/laas_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module laas_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/learning_automaton_action_selector.sv =====
// Top level of the learning automaton action selector (linear reward-penalty).
// Depends on laas_pkg and laas_ram.
//
// Usage: input items arrive on i_in_valid / o_in_stall and carry a mode and its
// operands. Every item produces exactly one result item on o_out_valid /
// i_out_stall, holding the last selected action, the saturating iteration count
// and the history fill, all taken after the item has taken effect.
// Configuration registers (reward rate, penalty rate, actions in use, history
// length) are written through i_cfg_valid / o_cfg_ready with a register index.
// Items are worked on one at a time by a sequencer around the probability RAM
// and the initial-value RAM, both with registered read data.
// Steps, in order: a load or an unused mode goes straight to the result; a
// select reads and compares each action in turn until one action past the
// match, or up to the last action in use; a restore reads each of the 16
// initial values and writes it to the probability table; and an update, per
// history entry, fetches the entry, forms two rate products, then reads,
// loads, multiplies and multiplies-with-write per action.
// The single RAM read port and the shared multipliers set this sequence.
// The result sits in an output register; a new item is taken the cycle after it
// has been delivered. When the receiver stalls the result holds and input stalls.
// Reset clears all control state and marks every table entry as zero by
// clearing per-entry valid bits; no clearing pass is needed.
module learning_automaton_action_selector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_random_fraction,
    input  logic [16:0] i_reinforcement,
    input  logic [3:0]  i_action_index,
    input  logic [32:0] i_probability_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_selected_action,
    output logic [31:0] o_iteration_count,
    output logic [2:0]  o_history_fill,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [32:0] i_cfg_data
);
    localparam int MAX_ACTIONS = laas_pkg::MAX_ACTIONS;
    localparam int MAX_HISTORY = laas_pkg::MAX_HISTORY;
    localparam int AW = $clog2(MAX_ACTIONS);
    localparam int HW = $clog2(MAX_HISTORY + 1);
    localparam int HIW = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEL_R = 4'd1;
    localparam logic [3:0] S_SEL_C = 4'd2;
    localparam logic [3:0] S_UP_H  = 4'd3;
    localparam logic [3:0] S_UP_R  = 4'd4;
    localparam logic [3:0] S_UP_M1 = 4'd5;
    localparam logic [3:0] S_UP_M2 = 4'd6;
    localparam logic [3:0] S_UP_W  = 4'd7;
    localparam logic [3:0] S_RS_R  = 4'd8;
    localparam logic [3:0] S_RS_W  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;
    localparam logic [3:0] S_UP_AB = 4'd11;
    localparam logic [3:0] S_UP_CB = 4'd12;

    // Configuration.
    logic [32:0] r_reward, r_penalty;
    logic [4:0]  r_actions;
    logic [2:0]  r_hlen;

    // Control state.
    logic [3:0]  r_state;
    logic [31:0] r_iter;
    logic [3:0]  r_last;
    logic [HW-1:0] r_hcnt;
    logic [3:0]  r_hist [MAX_HISTORY];
    logic [MAX_ACTIONS-1:0] r_pvalid, r_ivalid;
    logic        r_out_valid;

    // Item operands and working registers.
    logic [31:0] r_rand;
    logic [16:0] r_rein;
    logic [AW:0] r_idx;
    logic [HW-1:0] r_k;
    logic [32:0] r_cum;
    logic        r_found;
    logic [32:0] r_ab, r_cb, r_p, r_t1;
    logic [3:0]  r_used;

    // Derived clamped counts.
    logic [6:0]  n_used;
    logic [3:0]  h_used;
    always_comb begin
        if (r_actions < 5'd2) begin
            n_used = 7'd2;
        end else if (32'(r_actions) > MAX_ACTIONS) begin
            n_used = 7'(MAX_ACTIONS);
        end else begin
            n_used = 7'(r_actions);
        end
        if (r_hlen < 3'd1) begin
            h_used = 4'd1;
        end else if (32'(r_hlen) > MAX_HISTORY) begin
            h_used = 4'(MAX_HISTORY);
        end else begin
            h_used = 4'(r_hlen);
        end
    end

    // RAMs.
    logic          p_we, i_we;
    logic [AW-1:0] p_waddr, ram_raddr;
    logic [32:0]   p_wdata, p_rraw, i_rraw, p_rd, i_rd;
    logic [AW-1:0] r_raddr_q;

    laas_ram #(.WIDTH(33), .DEPTH(MAX_ACTIONS)) u_prob (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(ram_raddr), .o_rdata(p_rraw));
    laas_ram #(.WIDTH(33), .DEPTH(MAX_ACTIONS)) u_init (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(p_waddr), .i_wdata(p_wdata),
        .i_raddr(ram_raddr), .o_rdata(i_rraw));

    assign p_rd = r_pvalid[r_raddr_q] ? p_rraw : 33'd0;
    assign i_rd = r_ivalid[r_raddr_q] ? i_rraw : 33'd0;
    assign ram_raddr = r_idx[AW-1:0];

    // Saturated input probability word.
    logic [32:0] val_sat;
    assign val_sat = (i_probability_value > laas_pkg::ONE_Q32) ? laas_pkg::ONE_Q32
                                                                 : i_probability_value;

    // Shared multiplier, Q0.32 x Q0.32 rounded; one use per state.
    logic [32:0] mx, my, mq;
    logic [63:0] mprod;
    assign mprod = mx[31:0] * my[31:0];
    always_comb begin
        if (mx[32]) begin
            mq = my;
        end else if (my[32]) begin
            mq = mx;
        end else begin
            mq = 33'((mprod + 64'h8000_0000) >> 32);
        end
    end

    // Reinforcement of the current age in Q0.24.
    logic [16:0] rein_sat;
    logic [24:0] beta24, nbeta24;
    logic [HW-1:0] age;
    assign rein_sat = (r_rein > 17'd65536) ? 17'd65536 : r_rein;
    assign age = r_hcnt - 1'b1 - r_k;
    assign beta24 = {rein_sat, 8'd0} >> age[2:0];
    assign nbeta24 = laas_pkg::ONE_Q24 - beta24;

    // Rate-times-beta products, 33 x 25 bits, each in its own state.
    logic [57:0] rb_prod;
    assign rb_prod = (r_state == S_UP_AB) ? r_reward * beta24 : r_penalty * nbeta24;
    logic [32:0] rb_q;
    assign rb_q = 33'((rb_prod + 58'h80_0000) >> 24);

    // Penalty share table: round(2^32 / (n-1)), ties up, built at elaboration.
    logic [32:0] recip_tab [2:MAX_ACTIONS];
    for (genvar g = 2; g <= MAX_ACTIONS; g++) begin : g_recip
        localparam logic [33:0] DIV = 34'(g - 1);
        localparam logic [32:0] RECIP = 33'((34'h1_0000_0000 + (DIV >> 1)) / DIV);
        assign recip_tab[g] = RECIP;
    end

    logic [32:0] share;
    always_comb begin
        share = laas_pkg::ONE_Q32;
        for (int e = 2; e <= MAX_ACTIONS; e++) begin
            if (32'(n_used) == e) begin
                share = recip_tab[e];
            end
        end
    end

    logic chosen;
    assign chosen = (r_idx == {1'b0, r_used});

    // Operand selection for the multiplier: the reward term while the word is
    // held in r_p, then the penalty term in the write cycle.
    always_comb begin
        mx = r_ab;
        my = r_p;
        if (r_state == S_UP_M2) begin
            mx = r_ab;
            my = chosen ? laas_pkg::ONE_Q32 - r_p : r_p;
        end else if (r_state == S_UP_W) begin
            mx = r_cb;
            if (chosen) begin
                my = r_p;
            end else begin
                my = (share >= r_p) ? share - r_p : r_p - share;
            end
        end
    end

    // Final signed sum for the written probability.
    logic signed [35:0] v;
    always_comb begin
        v = $signed({3'd0, r_p});
        if (chosen) begin
            v = v + $signed({3'd0, r_t1}) - $signed({3'd0, mq});
        end else if (share >= r_p) begin
            v = v - $signed({3'd0, r_t1}) + $signed({3'd0, mq});
        end else begin
            v = v - $signed({3'd0, r_t1}) - $signed({3'd0, mq});
        end
    end
    logic [32:0] v_clamp;
    assign v_clamp = v < 0 ? 33'd0 :
                     (v > $signed({3'd0, laas_pkg::ONE_Q32}) ? laas_pkg::ONE_Q32 : v[32:0]);

    logic in_acc, out_acc, last_idx, bad_idx;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_valid;
    assign last_idx = ({1'b0, r_idx} + 1'b1) >= (AW + 1 + 1)'(n_used);
    assign bad_idx  = (AW < 4) && (32'(i_action_index) >= MAX_ACTIONS);

    // Select comparison on the fetched word.
    logic [33:0] top;
    assign top = {1'b0, r_cum} + {1'b0, p_rd};
    logic hit;
    assign hit = !r_found && {2'b0, r_rand} >= {1'b0, r_cum} && {2'b0, r_rand} <= top;
    logic [3:0] push_act;
    assign push_act = hit ? 4'(r_idx) : r_last;

    // Write port control.
    always_comb begin
        p_we = 1'b0;
        i_we = 1'b0;
        p_waddr = r_idx[AW-1:0];
        p_wdata = v_clamp;
        if (in_acc && (i_mode == laas_pkg::MODE_LOAD_IC || i_mode == laas_pkg::MODE_LOAD_C)
            && !bad_idx) begin
            p_we = 1'b1;
            i_we = (i_mode == laas_pkg::MODE_LOAD_IC);
            p_waddr = i_action_index[AW-1:0];
            p_wdata = val_sat;
        end else if (r_state == S_UP_W) begin
            p_we = 1'b1;
        end else if (r_state == S_RS_W) begin
            p_we = 1'b1;
            p_waddr = r_raddr_q;
            p_wdata = i_rd;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_raddr_q <= ram_raddr;
        if (!i_rst_n) begin
            r_reward <= 33'd4295;
            r_penalty <= 33'd0;
            r_actions <= 5'd16;
            r_hlen <= 3'd1;
            r_state <= S_IDLE;
            r_iter <= 32'd0;
            r_last <= 4'd0;
            r_hcnt <= '0;
            r_pvalid <= '0;
            r_ivalid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    laas_pkg::CFG_REWARD:
                        r_reward <= i_cfg_data > laas_pkg::ONE_Q32 ? laas_pkg::ONE_Q32
                                                                    : i_cfg_data;
                    laas_pkg::CFG_PENALTY:
                        r_penalty <= i_cfg_data > laas_pkg::ONE_Q32 ? laas_pkg::ONE_Q32
                                                                     : i_cfg_data;
                    laas_pkg::CFG_ACTIONS: r_actions <= i_cfg_data[4:0];
                    laas_pkg::CFG_HISTORY: r_hlen <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            // A restore copies a never-loaded entry as zero, so marking it
            // valid keeps it reading as zero.
            if (p_we) begin
                r_pvalid[p_waddr] <= 1'b1;
            end
            if (i_we) begin
                r_ivalid[p_waddr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_rand <= i_random_fraction;
                        r_rein <= i_reinforcement;
                        r_idx <= '0;
                        r_k <= '0;
                        r_cum <= '0;
                        r_found <= 1'b0;
                        case (i_mode)
                            laas_pkg::MODE_SELECT:  r_state <= S_SEL_R;
                            laas_pkg::MODE_UPDATE:  r_state <= S_UP_H;
                            laas_pkg::MODE_RESTORE: r_state <= S_RS_R;
                            default:                r_state <= S_DONE;
                        endcase
                    end
                end
                S_SEL_R: r_state <= S_SEL_C;
                S_SEL_C: begin
                    if (hit) begin
                        r_found <= 1'b1;
                        r_last <= 4'(r_idx);
                    end
                    r_cum <= top[32:0];
                    if (last_idx || r_found) begin
                        r_state <= S_DONE;
                        if (r_iter != 32'hFFFF_FFFF) begin
                            r_iter <= r_iter + 1'b1;
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_SEL_R;
                    end
                end
                S_UP_H: begin
                    if (r_k >= r_hcnt) begin
                        r_state <= S_DONE;
                    end else begin
                        r_used <= r_hist[r_k[HIW-1:0]];
                        r_idx <= '0;
                        r_state <= S_UP_AB;
                    end
                end
                S_UP_AB: begin
                    r_ab <= rb_q;
                    r_state <= S_UP_CB;
                end
                S_UP_CB: begin
                    r_cb <= rb_q;
                    r_state <= S_UP_R;
                end
                S_UP_R:  r_state <= S_UP_M1;
                S_UP_M1: begin
                    r_p <= p_rd;
                    r_state <= S_UP_M2;
                end
                S_UP_M2: begin
                    r_t1 <= mq;
                    r_state <= S_UP_W;
                end
                S_UP_W: begin
                    if (last_idx) begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_UP_H;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_UP_R;
                    end
                end
                S_RS_R: r_state <= S_RS_W;
                S_RS_W: begin
                    if (32'(r_idx) >= MAX_ACTIONS - 1) begin
                        r_hcnt <= '0;
                        r_last <= 4'd0;
                        r_iter <= 32'd0;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= S_RS_R;
                    end
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // History push happens once, as a select finishes its scan. A full
            // history drops its oldest entry and takes the new one on top.
            if (r_state == S_SEL_C && (last_idx || r_found)) begin
                if ({{(4 - HW + 1){1'b0}}, r_hcnt} >= {1'b0, h_used} && r_hcnt != '0) begin
                    for (int j = 0; j < MAX_HISTORY - 1; j++) begin
                        r_hist[j] <= (HW'(j) == r_hcnt - 1'b1) ? push_act : r_hist[j + 1];
                    end
                    if (r_hcnt == HW'(MAX_HISTORY)) begin
                        r_hist[MAX_HISTORY - 1] <= push_act;
                    end
                end else begin
                    r_hist[HIW'(r_hcnt)] <= push_act;
                    r_hcnt <= r_hcnt + 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_selected_action = r_last;
    assign o_iteration_count = r_iter;
    assign o_history_fill = 3'(r_hcnt);

    // The history never holds more than its storage.
    a_hcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hcnt) <= MAX_HISTORY) else $error("history overfilled");
    // A result is only raised from the final sequencer step.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE) else $error("stray result");
    // No item is taken while a result waits.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> o_in_stall) else $error("item taken over result");
endmodule

// ===== tb/learning_automaton_action_selector_tb.sv =====
// Self-checking testbench for learning_automaton_action_selector.
// Depends on laas_pkg and the selector RTL; a built-in predictor or a typed row checks every result.
`timescale 1ns / 100ps

module learning_automaton_action_selector_tb;

    localparam int NACT = 16;
    localparam int NHIST = 4;
    localparam int DRAIN_CYCLES = 500;

    typedef struct packed {
        logic [3:0]  sel;
        logic [31:0] iters;
        logic [2:0]  fill;
    } t_status;

    typedef struct {
        logic [2:0]  mode;
        logic [31:0] frac;
        logic [16:0] rein;
        logic [3:0]  idx;
        logic [32:0] pval;
        bit          typed;
        t_status     want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_mode;
    logic [31:0] i_random_fraction;
    logic [16:0] i_reinforcement;
    logic [3:0]  i_action_index;
    logic [32:0] i_probability_value;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_selected_action;
    logic [31:0] o_iteration_count;
    logic [2:0]  o_history_fill;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [32:0] i_cfg_data;

    learning_automaton_action_selector u_top (.*);

    // Predictor state: a private copy of the tables, history and registers.
    logic [32:0] prob_q [NACT];
    logic [32:0] init_q [NACT];
    logic [3:0]  hist [NHIST];
    int unsigned hist_cnt;
    logic [3:0]  last_act;
    logic [31:0] iter_cnt;
    logic [32:0] rate_a;
    logic [32:0] rate_c;
    logic [4:0]  cfg_n;
    logic [2:0]  cfg_h;

    t_status status_q[$];
    int      errors;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    int      hold_cycles;
    int      items_sent;

    function automatic logic [32:0] clip_one(logic [32:0] v);
        return (v > laas_pkg::ONE_Q32) ? laas_pkg::ONE_Q32 : v;
    endfunction

    // Q0.32 product rounded to nearest, ties up.
    function automatic longint unsigned qmul(longint unsigned x, longint unsigned y);
        if (x >= 64'h1_0000_0000) return y;
        if (y >= 64'h1_0000_0000) return x;
        return (x * y + 64'h8000_0000) >> 32;
    endfunction

    function automatic int unsigned actions_eff();
        if (cfg_n < 2) return 2;
        if (cfg_n > NACT) return NACT;
        return cfg_n;
    endfunction

    function automatic int unsigned depth_eff();
        if (cfg_h < 1) return 1;
        if (cfg_h > NHIST) return NHIST;
        return cfg_h;
    endfunction

    // One reinforcement step for a single history entry.
    function automatic void reinforce(int unsigned chosen, longint unsigned beta24);
        int unsigned n;
        longint unsigned share, ab, cb, p;
        longint v;
        n = actions_eff();
        share = (64'h1_0000_0000 + (n - 1) / 2) / (n - 1);
        ab = (longint'(rate_a) * beta24 + 64'h80_0000) >> 24;
        cb = (longint'(rate_c) * (64'h100_0000 - beta24) + 64'h80_0000) >> 24;
        for (int i = 0; i < n; i++) begin
            p = prob_q[i];
            v = p;
            if (i == chosen) begin
                v += qmul(ab, 64'h1_0000_0000 - p);
                v -= qmul(cb, p);
            end else begin
                v -= qmul(ab, p);
                if (share >= p) v += qmul(cb, share - p);
                else v -= qmul(cb, p - share);
            end
            if (v < 0) v = 0;
            if (v > 64'sh1_0000_0000) v = 64'sh1_0000_0000;
            prob_q[i] = v[32:0];
        end
    endfunction

    function automatic t_status predict_status(t_row it);
        t_status s;
        longint unsigned cum, top, r, rein;
        int unsigned n;
        case (it.mode)
            laas_pkg::MODE_SELECT: begin
                n = actions_eff();
                cum = 0;
                r = it.frac;
                for (int i = 0; i < n; i++) begin
                    top = cum + prob_q[i];
                    if (cum <= r && r <= top) begin
                        last_act = i;
                        break;
                    end
                    cum = top;
                end
                if (iter_cnt != 32'hFFFF_FFFF) iter_cnt++;
                if (hist_cnt >= depth_eff() && hist_cnt > 0) begin
                    for (int k = 0; k < NHIST - 1; k++) hist[k] = hist[k + 1];
                    hist_cnt--;
                end
                if (hist_cnt < NHIST) begin
                    hist[hist_cnt] = last_act;
                    hist_cnt++;
                end
            end
            laas_pkg::MODE_UPDATE: begin
                rein = (it.rein > 17'd65536) ? 65536 : it.rein;
                for (int k = 0; k < hist_cnt; k++)
                    reinforce(hist[k], (rein << 8) >> ((hist_cnt - 1 - k) & 7));
            end
            laas_pkg::MODE_RESTORE: begin
                prob_q = init_q;
                hist_cnt = 0;
                last_act = 0;
                iter_cnt = 0;
            end
            laas_pkg::MODE_LOAD_IC: begin
                init_q[it.idx] = clip_one(it.pval);
                prob_q[it.idx] = clip_one(it.pval);
            end
            laas_pkg::MODE_LOAD_C: prob_q[it.idx] = clip_one(it.pval);
            default: ;
        endcase
        s.sel = last_act;
        s.iters = iter_cnt;
        s.fill = hist_cnt[2:0];
        return s;
    endfunction

    function automatic t_row mk(logic [2:0] m, logic [31:0] f, logic [16:0] b,
                                logic [3:0] x, logic [32:0] v);
        t_row t;
        t.mode = m;
        t.frac = f;
        t.rein = b;
        t.idx = x;
        t.pval = v;
        t.typed = 0;
        t.want = '0;
        return t;
    endfunction

    function automatic t_row mk_typed(logic [2:0] m, logic [31:0] f, logic [3:0] s,
                                      logic [31:0] c, logic [2:0] h);
        t_row t;
        t = mk(m, f, 17'd0, 4'd0, 33'd0);
        t.typed = 1;
        t.want = '{sel: s, iters: c, fill: h};
        return t;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest legal run with the heaviest stalls.
    initial begin
        #80_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stall, or a long counted hold-off when asked for one.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
        end
    end

    // Result checker: every delivered item is compared with the oldest queued expectation.
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{sel: o_selected_action, iters: o_iteration_count, fill: o_history_fill};
            if (status_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item: %p", got);
            end else begin
                want = status_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
                end
            end
        end
    end

    // Valid stays high after an accepted item so that the next one can follow
    // at once; an idle cycle or drain() drops it.
    task automatic send_item(t_row it);
        t_status s;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= it.mode;
        i_random_fraction <= it.frac;
        i_reinforcement <= it.rein;
        i_action_index <= it.idx;
        i_probability_value <= it.pval;
        do @(posedge i_clk); while (o_in_stall);
        s = predict_status(it);
        // A typed expectation stands in place of the prediction for that row.
        status_q.push_back(it.typed ? it.want : s);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Writes follow back to back; the caller drops i_cfg_valid after the last one.
    task automatic write_reg(logic [1:0] idx, logic [32:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            laas_pkg::CFG_REWARD:  rate_a = clip_one(data);
            laas_pkg::CFG_PENALTY: rate_c = clip_one(data);
            laas_pkg::CFG_ACTIONS: cfg_n = data[4:0];
            default:               cfg_h = data[2:0];
        endcase
        @(negedge i_clk);
    endtask

    // Let the block go quiet before registers change.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [32:0] rand_rate();
        case ($urandom_range(0, 5))
            0: return 33'd0;
            1: return laas_pkg::ONE_Q32;
            2: return 33'h1_FFFF_FFFF;
            3: return {1'b0, $urandom()} >> $urandom_range(0, 31);
            default: return {1'b0, $urandom()} >> $urandom_range(4, 12);
        endcase
    endfunction

    // Random item, mostly selects and updates over a sane distribution.
    task automatic random_item();
        int unsigned pick, n;
        logic [16:0] b;
        pick = $urandom_range(0, 99);
        b = ($urandom_range(0, 9) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
        if (pick < 40) begin
            send_item(mk(laas_pkg::MODE_SELECT, $urandom(), 17'($urandom()), 4'($urandom()),
                         {1'b0, $urandom()}));
        end else if (pick < 70) begin
            send_item(mk(laas_pkg::MODE_UPDATE, $urandom(), b, 4'($urandom()),
                         {1'b0, $urandom()}));
        end else if (pick < 80) begin
            send_item(mk(laas_pkg::MODE_LOAD_C, $urandom(), b, 4'($urandom()),
                         {1'($urandom()), $urandom()} >> $urandom_range(0, 8)));
        end else if (pick < 84) begin
            send_item(mk(laas_pkg::MODE_LOAD_IC, $urandom(), b, 4'($urandom()),
                         {1'($urandom()), $urandom()} >> $urandom_range(0, 8)));
        end else if (pick < 87) begin
            send_item(mk(laas_pkg::MODE_RESTORE, $urandom(), b, 4'($urandom()), 33'd0));
        end else if (pick < 90) begin
            send_item(mk(3'($urandom_range(5, 7)), $urandom(), b, 4'($urandom()),
                         {1'($urandom()), $urandom()}));
        end else begin
            // Fresh, roughly uniform distribution over the actions in use.
            n = actions_eff();
            for (int i = 0; i < n; i++)
                send_item(mk(($urandom_range(0, 1) != 0) ? laas_pkg::MODE_LOAD_IC
                                                         : laas_pkg::MODE_LOAD_C,
                             $urandom(), b, 4'(i),
                             (laas_pkg::ONE_Q32 / n) + 33'($urandom_range(0, 4096))
                             - 33'd2048));
        end
    endtask

    initial begin
        t_row dir[$];
        errors = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_cycles = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_mode = laas_pkg::MODE_SELECT;
        i_random_fraction = '0;
        i_reinforcement = '0;
        i_action_index = '0;
        i_probability_value = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = laas_pkg::CFG_REWARD;
        i_cfg_data = '0;
        for (int i = 0; i < NACT; i++) begin
            prob_q[i] = '0;
            init_q[i] = '0;
        end
        for (int k = 0; k < NHIST; k++) hist[k] = '0;
        hist_cnt = 0;
        last_act = 0;
        iter_cnt = 0;
        rate_a = 33'd4295;
        rate_c = 33'd0;
        cfg_n = 5'd16;
        cfg_h = 3'd1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part: empty tables first, then extremes and every mode.
        dir.push_back(mk_typed(laas_pkg::MODE_SELECT, 32'd0, 4'd0, 32'd1, 3'd1));
        dir.push_back(mk_typed(3'd7, 32'hFFFF_FFFF, 4'd0, 32'd1, 3'd1));
        dir.push_back(mk_typed(laas_pkg::MODE_SELECT, 32'hFFFF_FFFF, 4'd0, 32'd2, 3'd1));
        dir.push_back(mk(laas_pkg::MODE_LOAD_IC, 32'd0, 17'd0, 4'd0, 33'h1_FFFF_FFFF));
        dir.push_back(mk(laas_pkg::MODE_LOAD_IC, 32'd0, 17'd0, 4'd15, 33'h0_8000_0000));
        dir.push_back(mk(laas_pkg::MODE_LOAD_C, 32'd0, 17'd0, 4'd0, 33'h0_4000_0000));
        dir.push_back(mk(laas_pkg::MODE_LOAD_C, 32'd0, 17'd0, 4'd1, 33'h0_4000_0000));
        dir.push_back(mk(laas_pkg::MODE_LOAD_C, 32'd0, 17'd0, 4'd2, 33'h0_8000_0000));
        dir.push_back(mk(laas_pkg::MODE_SELECT, 32'h5000_0000, 17'd0, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_SELECT, 32'hFFFF_FFFF, 17'd0, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_UPDATE, 32'd0, 17'h1_FFFF, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_UPDATE, 32'd0, 17'd0, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_UPDATE, 32'd0, 17'd65536, 4'd0, 33'd0));
        dir.push_back(mk(3'd5, 32'd0, 17'd0, 4'd9, 33'h1_FFFF_FFFF));
        dir.push_back(mk(3'd6, 32'hAAAA_AAAA, 17'h1_5555, 4'd5, 33'h0_5555_5555));
        dir.push_back(mk(laas_pkg::MODE_RESTORE, 32'd0, 17'd0, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_SELECT, 32'h8000_0000, 17'd0, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_SELECT, 32'hFFFF_FFFF, 17'd0, 4'd0, 33'd0));
        dir.push_back(mk(laas_pkg::MODE_UPDATE, 32'd0, 17'd32768, 4'd0, 33'd0));
        dir.push_back(mk_typed(laas_pkg::MODE_RESTORE, 32'd0, 4'd0, 32'd0, 3'd0));
        foreach (dir[i]) send_item(dir[i]);
        drain();

        // Random part: six register settings across the three idling regimes,
        // about 205 items each.
        for (int ph = 0; ph < 6; ph++) begin
            int phase_end;
            write_reg(laas_pkg::CFG_REWARD,
                      (ph == 0) ? laas_pkg::ONE_Q32 : (ph == 1) ? 33'd0 : rand_rate());
            write_reg(laas_pkg::CFG_PENALTY,
                      (ph == 0) ? 33'd0 : (ph == 1) ? 33'h1_FFFF_FFFF : rand_rate());
            write_reg(laas_pkg::CFG_ACTIONS, (ph == 0) ? 33'd2 : (ph == 1) ? 33'd16 :
                                             (ph == 2) ? 33'd31 : (ph == 3) ? 33'd0 :
                                             33'($urandom_range(2, 16)));
            write_reg(laas_pkg::CFG_HISTORY, (ph == 0) ? 33'd4 : (ph == 1) ? 33'd1 :
                                             (ph == 2) ? 33'd7 : (ph == 3) ? 33'd0 :
                                             33'($urandom_range(1, 4)));
            i_cfg_valid <= 1'b0;
            snd_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 63 : 0;
            rcv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 32 : 0;
            phase_end = items_sent + 205;
            for (int n = 0; items_sent < phase_end; n++) begin
                // Once per phase the receiver holds off while items keep coming.
                if (n == 60) hold_cycles = 600;
                random_item();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && status_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
